// ===== rtl/bdq_pkg.sv =====
// Package for the bounded deque: sizes, operation and status codes, and the
// request, result and internal command structs. No dependencies.
package bdq_pkg;

	localparam int DEPTH  = 64;
	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int CFG_W  = 7;
	localparam int OUT_CNT_W = 7;
	localparam int CAP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(64);

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
	} bdq_req_t;

	typedef struct packed {
		logic signed [31:0]     data;
		status_t                status;
		logic [OUT_CNT_W-1:0]   count;
	} bdq_rsp_t;

	// One classified request on its way from the front end to the store.
	typedef struct packed {
		logic                 wr;
		logic                 rd;
		logic [SLOT_W-1:0]    slot;
		logic signed [31:0]   value;
		status_t              status;
		logic [OUT_CNT_W-1:0] count;
	} bdq_cmd_t;

endpackage

// ===== rtl/bdq_front.sv =====
// Front end of the bounded deque: capacity register, head pointer and fill
// count; classifies each request and forms a store command. Uses bdq_pkg.
module bdq_front import bdq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  bdq_req_t         request,
	input  logic             cfg_write,
	input  logic [CFG_W-1:0] cfg_data,
	output bdq_cmd_t         cmd
);

	logic [CFG_W-1:0]  capacity_q;
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  fill_q;

	logic [SLOT_W-1:0] head_next;
	logic [CNT_W-1:0]  fill_next;
	logic [CAP_W-1:0]  cap_eff;
	logic              is_full;
	logic              is_empty;
	logic [SUM_W-1:0]  tail_sum;
	logic [SUM_W-1:0]  tail_wrap;
	logic [SUM_W-1:0]  last_sum;
	logic [SUM_W-1:0]  last_wrap;
	logic [SLOT_W-1:0] head_dec;
	logic [SLOT_W-1:0] head_inc;

	always_comb begin
		cap_eff = (CAP_W'(capacity_q) > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : CAP_W'(capacity_q);
		is_full  = CAP_W'(fill_q) >= cap_eff;
		is_empty = (fill_q == '0);

		// Slot just past the back, and slot of the back entry, modulo depth.
		tail_sum  = SUM_W'(head_q) + SUM_W'(fill_q);
		tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;
		last_sum  = tail_sum - SUM_W'(1);
		last_wrap = (last_sum >= SUM_W'(DEPTH)) ? last_sum - SUM_W'(DEPTH) : last_sum;
		head_dec  = (head_q == '0) ? SLOT_W'(DEPTH - 1) : head_q - SLOT_W'(1);
		head_inc  = (head_q == SLOT_W'(DEPTH - 1)) ? '0 : head_q + SLOT_W'(1);

		head_next  = head_q;
		fill_next  = fill_q;
		cmd.wr     = 1'b0;
		cmd.rd     = 1'b0;
		cmd.slot   = tail_wrap[SLOT_W-1:0];
		cmd.value  = request.value;
		cmd.status = ST_OK;

		case (request.op)
			OP_PUSH_BACK: begin
				if (is_full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.wr    = 1'b1;
					fill_next = fill_q + CNT_W'(1);
				end
			end
			OP_PUSH_FRONT: begin
				cmd.slot = head_dec;
				if (is_full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.wr    = 1'b1;
					head_next = head_dec;
					fill_next = fill_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				cmd.slot = head_q;
				if (is_empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.rd    = 1'b1;
					head_next = head_inc;
					fill_next = fill_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				cmd.slot = last_wrap[SLOT_W-1:0];
				if (is_empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.rd    = 1'b1;
					fill_next = fill_q - CNT_W'(1);
				end
			end
			default: begin
				cmd.status = ST_OK;
			end
		endcase

		cmd.count = OUT_CNT_W'(fill_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			head_q     <= '0;
			fill_q     <= '0;
		end else begin
			if (cfg_write) begin
				capacity_q <= cfg_data;
			end
			if (accept) begin
				head_q <= head_next;
				fill_q <= fill_next;
			end
		end
	end

endmodule

// ===== rtl/bdq_queue.sv =====
// Two-entry command queue between the deque front end and the store.
// Uses bdq_pkg for the command struct.
module bdq_queue import bdq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  bdq_cmd_t push_cmd,
	input  logic     pop,
	output logic     full,
	output logic     valid,
	output bdq_cmd_t pop_cmd
);

	bdq_cmd_t   slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;

	assign full    = (level_q == 2'd2);
	assign valid   = (level_q != 2'd0);
	assign pop_cmd = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// ===== rtl/bdq_back.sv =====
// Back end of the bounded deque: the entry memory and the result register.
// Carries out one queued command per cycle. Uses bdq_pkg.
module bdq_back import bdq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  bdq_cmd_t cmd,
	output logic     strobe,
	output bdq_rsp_t result
);

	logic signed [31:0]   mem [DEPTH];
	logic signed [31:0]   rdata_s1;
	logic                 valid_s1;
	logic                 rd_s1;
	status_t              status_s1;
	logic [OUT_CNT_W-1:0] count_s1;

	// Write and registered read share the command's slot.
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd.wr) begin
			mem[cmd.slot] <= cmd.value;
		end
		rdata_s1  <= mem[cmd.slot];
		rd_s1     <= cmd.rd;
		status_s1 <= cmd.status;
		count_s1  <= cmd.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_valid;
		end
	end

	assign strobe        = valid_s1;
	assign result.data   = rd_s1 ? rdata_s1 : 32'sd0;
	assign result.status = status_s1;
	assign result.count  = count_s1;

endmodule

// ===== rtl/bounded_deque.sv =====
// Bounded double-ended queue of signed 32-bit values: push back, push front,
// pop front and pop back, with a full/empty error status and the fill count
// in every result. Sustained rate is one request per clock. A request taken at
// a rising edge (start high, busy low) yields exactly one result. Strobe is high
// for one cycle per result: the request is registered in the command queue, then
// the synchronous read of the entry memory registers the result. The receiver
// cannot stall the block, so the back end drains a command in every cycle it
// holds one; the command queue never holds more than one entry and busy never
// rises. The user must write capacity through the cfg channel (always ready)
// only while idle; the block does not enforce this. Values above the memory
// depth act as the depth, zero makes every push full.
// Depends on bdq_pkg, bdq_front, bdq_queue and bdq_back.
module bounded_deque import bdq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  bdq_req_t         request,
	output logic             strobe,
	output bdq_rsp_t         result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	logic     accept;
	logic     queue_full;
	logic     queue_valid;
	bdq_cmd_t front_cmd;
	bdq_cmd_t back_cmd;

	// Take a request whenever the command queue has room.
	assign busy      = queue_full;
	assign accept    = start && !queue_full;
	assign cfg_ready = 1'b1;

	// Classify the request against head, count and capacity; advance pointers.
	bdq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.request   (request),
		.cfg_write (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (front_cmd)
	);

	// Hold classified commands until the store takes them; drain every cycle.
	bdq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_cmd (front_cmd),
		.pop      (queue_valid),
		.full     (queue_full),
		.valid    (queue_valid),
		.pop_cmd  (back_cmd)
	);

	// Write or read the entry memory and present the result.
	bdq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_valid),
		.cmd       (back_cmd),
		.strobe    (strobe),
		.result    (result)
	);

endmodule
